>>> design/pudt_pkg.sv
`default_nettype none

package pudt_pkg;

   // Field widths fixed by the point format.
   localparam int COORD_W = 16;
   localparam int OUT_W   = 19;
   localparam int ROW_W   = 64;
   localparam int BYTE_W  = 8;
   localparam int PROD_W  = 2 * COORD_W;

   // Saturation limits of a transformed coordinate.
   localparam int OUT_MAX = 262143;
   localparam int OUT_MIN = -262144;

   // Reset contents of the transform rows: identity with no translation.
   localparam logic [ROW_W-1:0] ROW_X_RESET = 64'd16384;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'd1073741824;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'd70368744177664;
   localparam logic [BYTE_W-1:0] KEEP_EVERY_RESET = 8'd1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OUT_W-1:0] out_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ROW_W-1:0] row_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_ROW_X      = 2'd0,
      CSR_ROW_Y      = 2'd1,
      CSR_ROW_Z      = 2'd2,
      CSR_KEEP_EVERY = 2'd3
   } csr_index_type;

   // Load enables for the two arithmetic stages of a transform row.
   typedef struct packed {
      logic prod;
      logic out;
   } stage_en_type;

endpackage

`default_nettype wire

>>> design/pudt_decim.sv
`default_nettype none

module pudt_decim (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   eof,
   input  logic [7:0]             keep_every,
   output logic                   keep
);
   import pudt_pkg::*;

   logic [7:0] phase_ff;
   logic [7:0] phase_in;
   logic [7:0] factor;
   logic [8:0] next_phase;
   logic       wrap;

   // A factor of zero behaves as one, so every point is kept.
   always_comb begin
      factor     = (keep_every == 8'd0) ? 8'd1 : keep_every;
      next_phase = {1'b0, phase_ff} + 9'd1;
      wrap       = eof || (next_phase >= {1'b0, factor});
      if (step) begin
         phase_in = wrap ? 8'd0 : next_phase[7:0];
      end else begin
         phase_in = phase_ff;
      end
      keep = (phase_ff == 8'd0);
   end

   // Phase within the current decimation group.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // The phase always wraps before it can reach the top code.
   a_phase_below_top: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 8'hFF)
      else $error("decimation phase reached its top code");

   // The item after an end of frame always starts a new group.
   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && eof) |=> (phase_ff == 8'd0))
      else $error("phase did not restart after end of frame");

   // With a factor of one or zero every point is kept.
   a_keep_all: assert property (@(posedge clock) disable iff (reset)
      (step && (keep_every <= 8'd1)) |=> keep)
      else $error("point dropped although every point should be kept");

endmodule

`default_nettype wire

>>> design/pudt_row.sv
`default_nettype none

module pudt_row #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                   clock,
   input  pudt_pkg::stage_en_type stage_en,
   input  pudt_pkg::row_type      row,
   input  pudt_pkg::coord_type    px,
   input  pudt_pkg::coord_type    py,
   input  pudt_pkg::coord_type    pz,
   output pudt_pkg::out_type      q
);
   import pudt_pkg::*;

   // Four guard bits cover the three products, the rounding constant and the translation.
   localparam int SUM_W = PROD_W + 4;
   localparam logic signed [SUM_W-1:0] ROUND  = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

   coord_type                coef_x;
   coord_type                coef_y;
   coord_type                coef_z;
   coord_type                trans;
   logic signed [PROD_W-1:0] prod_x_in;
   logic signed [PROD_W-1:0] prod_y_in;
   logic signed [PROD_W-1:0] prod_z_in;
   logic signed [PROD_W-1:0] prod_x_ff;
   logic signed [PROD_W-1:0] prod_y_ff;
   logic signed [PROD_W-1:0] prod_z_ff;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  rounded;
   logic signed [SUM_W-1:0]  total;
   out_type                  q_in;
   out_type                  q_ff;

   // Unpack the row and form the three coefficient products.
   always_comb begin
      coef_x    = row[15:0];
      coef_y    = row[31:16];
      coef_z    = row[47:32];
      trans     = row[63:48];
      prod_x_in = coef_x * px;
      prod_y_in = coef_y * py;
      prod_z_in = coef_z * pz;
   end

   always_ff @(posedge clock) begin
      if (stage_en.prod) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
   end

   // Sum, round half up to whole millimetres, translate and saturate.
   always_comb begin
      sum     = SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff) + SUM_W'(prod_z_ff) + ROUND;
      rounded = sum >>> COEF_FRAC_BITS;
      total   = rounded + SUM_W'(trans);
      if (total > SAT_HI) begin
         q_in = OUT_W'(SAT_HI);
      end else if (total < SAT_LO) begin
         q_in = OUT_W'(SAT_LO);
      end else begin
         q_in = OUT_W'(total);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.out) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

>>> design/point_unpack_decimate_transform.sv
// Point unpack, decimate and rigid transform.
//
// Input channel (req_*): one depth-camera point per transaction, signed x, y, z
// in millimetres, two colour words and an end-of-frame flag. Result channel
// (rsp_*): the transformed point, saturated to 19 signed bits, with its red,
// green and blue bytes. Within a frame one point in keep_every is kept,
// starting with the first; a dropped point is accepted and gives no result.
// Configuration (csr_*): a write to one of the three transform rows or the
// decimation factor, taken on any clock edge with csr_we high; the user must
// write only while idle, as the block does not enforce it. The input register
// loads at the accepting edge, then the product registers, then the result
// registers together with rsp_valid. Throughput: one point per cycle while
// rsp_ready stays high, set by the three-stage pipeline whose stages each
// hold one transaction and advance independently.
// When the receiver stalls the pipeline keeps filling until all three stages
// hold a transaction; req_ready then drops until rsp_ready returns.
// Reset restores the identity transform, a factor of one and phase zero, and
// empties the pipeline.

`default_nettype none

module point_unpack_decimate_transform #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pudt_pkg::coord_type     req_px_mm,
   input  pudt_pkg::coord_type     req_py_mm,
   input  pudt_pkg::coord_type     req_pz_mm,
   input  logic [15:0]             req_color_rg,
   input  logic [15:0]             req_color_b,
   input  logic                    req_end_of_frame,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pudt_pkg::out_type       rsp_qx_mm,
   output pudt_pkg::out_type       rsp_qy_mm,
   output pudt_pkg::out_type       rsp_qz_mm,
   output pudt_pkg::byte_type      rsp_red,
   output pudt_pkg::byte_type      rsp_green,
   output pudt_pkg::byte_type      rsp_blue,
   input  logic                    csr_we,
   input  pudt_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_wdata
);
   import pudt_pkg::*;

   row_type      row_x_ff;
   row_type      row_y_ff;
   row_type      row_z_ff;
   byte_type     keep_every_ff;

   logic         accept;
   logic         keep;
   logic         load0;
   logic         ready0;
   logic         ready1;
   logic         move01;
   logic         move12;
   stage_en_type stage_en;

   logic         v0_ff, v0_in;
   logic         v1_ff, v1_in;
   logic         v2_ff, v2_in;
   coord_type    px0_ff, py0_ff, pz0_ff;
   byte_type     red0_ff, green0_ff, blue0_ff;
   byte_type     red1_ff, green1_ff, blue1_ff;
   byte_type     red2_ff, green2_ff, blue2_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff      <= ROW_X_RESET;
         row_y_ff      <= ROW_Y_RESET;
         row_z_ff      <= ROW_Z_RESET;
         keep_every_ff <= KEEP_EVERY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_X:      row_x_ff      <= csr_wdata;
            CSR_ROW_Y:      row_y_ff      <= csr_wdata;
            CSR_ROW_Z:      row_z_ff      <= csr_wdata;
            CSR_KEEP_EVERY: keep_every_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Decimation decides at acceptance whether the point enters the pipeline.
   pudt_decim u_decim (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .eof        (req_end_of_frame),
      .keep_every (keep_every_ff),
      .keep       (keep)
   );

   // Per-stage flow control: a stage may load when it is empty or moves on.
   always_comb begin
      ready1       = !v2_ff || rsp_ready;
      ready0       = !v1_ff || ready1;
      req_ready    = !v0_ff || ready0;
      accept       = req_valid && req_ready;
      load0        = accept && keep;
      move01       = v0_ff && ready0;
      move12       = v1_ff && ready1;
      v0_in        = load0 || (v0_ff && !ready0);
      v1_in        = move01 || (v1_ff && !ready1);
      v2_in        = move12 || (v2_ff && !rsp_ready);
      stage_en.prod = move01;
      stage_en.out  = move12;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // Input register: the kept point and its colour bytes.
   always_ff @(posedge clock) begin
      if (load0) begin
         px0_ff    <= req_px_mm;
         py0_ff    <= req_py_mm;
         pz0_ff    <= req_pz_mm;
         red0_ff   <= req_color_rg[7:0];
         green0_ff <= req_color_rg[15:8];
         blue0_ff  <= req_color_b[7:0];
      end
   end

   // Colour bytes travel alongside the arithmetic stages.
   always_ff @(posedge clock) begin
      if (move01) begin
         red1_ff   <= red0_ff;
         green1_ff <= green0_ff;
         blue1_ff  <= blue0_ff;
      end
      if (move12) begin
         red2_ff   <= red1_ff;
         green2_ff <= green1_ff;
         blue2_ff  <= blue1_ff;
      end
   end

   // One transform row per output coordinate.
   pudt_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_x (
      .clock    (clock),
      .stage_en (stage_en),
      .row      (row_x_ff),
      .px       (px0_ff),
      .py       (py0_ff),
      .pz       (pz0_ff),
      .q        (rsp_qx_mm)
   );

   pudt_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_y (
      .clock    (clock),
      .stage_en (stage_en),
      .row      (row_y_ff),
      .px       (px0_ff),
      .py       (py0_ff),
      .pz       (pz0_ff),
      .q        (rsp_qy_mm)
   );

   pudt_row #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_row_z (
      .clock    (clock),
      .stage_en (stage_en),
      .row      (row_z_ff),
      .px       (px0_ff),
      .py       (py0_ff),
      .pz       (pz0_ff),
      .q        (rsp_qz_mm)
   );

   assign rsp_valid = v2_ff;
   assign rsp_red   = red2_ff;
   assign rsp_green = green2_ff;
   assign rsp_blue  = blue2_ff;

   // A dropped point never occupies the input register.
   a_drop_leaves_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && !keep && !v0_ff) |=> !v0_ff)
      else $error("dropped point entered the pipeline");

   // A kept point entering an empty pipeline reaches the output through the input, product and result registers.
   a_empty_latency: assert property (@(posedge clock) disable iff (reset)
      (load0 && !v0_ff && !v1_ff && !v2_ff) |-> ##3 rsp_valid)
      else $error("kept point did not reach the output on time");

endmodule

`default_nettype wire

>>> tb/sv/point_unpack_decimate_transform_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the point transform.
// It keeps its own copy of the transform rows, the decimation factor and the
// frame phase, predicts the result of every accepted point, and compares each
// result transaction with the oldest prediction still owed.
module point_unpack_decimate_transform_checker #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  pudt_pkg::coord_type     req_px_mm,
   input  pudt_pkg::coord_type     req_py_mm,
   input  pudt_pkg::coord_type     req_pz_mm,
   input  logic [15:0]             req_color_rg,
   input  logic [15:0]             req_color_b,
   input  logic                    req_end_of_frame,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pudt_pkg::out_type       rsp_qx_mm,
   input  pudt_pkg::out_type       rsp_qy_mm,
   input  pudt_pkg::out_type       rsp_qz_mm,
   input  pudt_pkg::byte_type      rsp_red,
   input  pudt_pkg::byte_type      rsp_green,
   input  pudt_pkg::byte_type      rsp_blue,
   input  logic                    csr_we,
   input  pudt_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_wdata,
   output int                      mismatch_count,
   output int                      results_owed
);
   import pudt_pkg::*;

   typedef struct packed {
      out_type  qx;
      out_type  qy;
      out_type  qz;
      byte_type red;
      byte_type green;
      byte_type blue;
   } point_out_type;

   // Local copy of the registers and the frame phase.
   row_type       row_x_copy;
   row_type       row_y_copy;
   row_type       row_z_copy;
   byte_type      keep_every_copy;
   int            frame_phase;
   int            factor;
   int            next_phase;
   point_out_type predicted;
   point_out_type observed;
   point_out_type predicted_points[$];

   // One output coordinate: exact dot product, round half up, add the
   // translation and clamp to 19 signed bits.
   function automatic out_type transform_row(row_type row, coord_type x, coord_type y,
                                             coord_type z);
      longint acc;
      longint r;
      acc = longint'($signed(row[15:0])) * longint'(x)
          + longint'($signed(row[31:16])) * longint'(y)
          + longint'($signed(row[47:32])) * longint'(z);
      r = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      r = r + longint'($signed(row[63:48]));
      if (r > OUT_MAX) r = OUT_MAX;
      if (r < OUT_MIN) r = OUT_MIN;
      return out_type'(r);
   endfunction

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         row_x_copy      = ROW_X_RESET;
         row_y_copy      = ROW_Y_RESET;
         row_z_copy      = ROW_Z_RESET;
         keep_every_copy = KEEP_EVERY_RESET;
         frame_phase     = 0;
         predicted_points.delete();
      end else begin
         // Register writes only happen while the block is idle.
         if (csr_we) begin
            case (csr_index)
               CSR_ROW_X: begin
                  row_x_copy = csr_wdata;
               end
               CSR_ROW_Y: begin
                  row_y_copy = csr_wdata;
               end
               CSR_ROW_Z: begin
                  row_z_copy = csr_wdata;
               end
               CSR_KEEP_EVERY: begin
                  keep_every_copy = csr_wdata[7:0];
               end
               default: begin
               end
            endcase
         end

         // Check a result transaction before taking in a new point, so that a
         // stray result can never be matched against this cycle's point.
         if (rsp_valid && rsp_ready) begin
            observed = '{rsp_qx_mm, rsp_qy_mm, rsp_qz_mm, rsp_red, rsp_green, rsp_blue};
            if (predicted_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                           $realtime, observed.qx, observed.qy, observed.qz,
                           observed.red, observed.green, observed.blue);
            end else begin
               predicted = predicted_points.pop_front();
               if (observed.qx !== predicted.qx || observed.qy !== predicted.qy ||
                   observed.qz !== predicted.qz || observed.red !== predicted.red ||
                   observed.green !== predicted.green || observed.blue !== predicted.blue)
               begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("%0t: result mismatch, expected x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                            $realtime, predicted.qx, predicted.qy, predicted.qz,
                            predicted.red, predicted.green, predicted.blue);
                     $display(", got x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                              observed.qx, observed.qy, observed.qz,
                              observed.red, observed.green, observed.blue);
                  end
               end
            end
         end

         // Decimation: keep the point at phase zero, then advance the phase,
         // wrapping at the factor or after the end of a frame.
         if (req_valid && req_ready) begin
            factor     = (keep_every_copy == 0) ? 1 : int'(keep_every_copy);
            next_phase = frame_phase + 1;
            if (frame_phase == 0) begin
               predicted.qx    = transform_row(row_x_copy, req_px_mm, req_py_mm, req_pz_mm);
               predicted.qy    = transform_row(row_y_copy, req_px_mm, req_py_mm, req_pz_mm);
               predicted.qz    = transform_row(row_z_copy, req_px_mm, req_py_mm, req_pz_mm);
               predicted.red   = req_color_rg[7:0];
               predicted.green = req_color_rg[15:8];
               predicted.blue  = req_color_b[7:0];
               predicted_points.push_back(predicted);
            end
            if (req_end_of_frame || next_phase >= factor)
               frame_phase = 0;
            else
               frame_phase = next_phase & 8'hFF;
         end
      end
      results_owed = predicted_points.size();
   end

endmodule

>>> tb/sv/point_unpack_decimate_transform_test.sv
`timescale 1ns / 1ps

module point_unpack_decimate_transform_test;
   import pudt_pkg::*;

   localparam int FRAC_BITS   = 14;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ROUNDS      = 10;
   localparam int ROUND_ITEMS = 55;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   coord_type     req_px_mm;
   coord_type     req_py_mm;
   coord_type     req_pz_mm;
   logic [15:0]   req_color_rg;
   logic [15:0]   req_color_b;
   logic          req_end_of_frame;
   logic          rsp_valid;
   logic          rsp_ready;
   out_type       rsp_qx_mm;
   out_type       rsp_qy_mm;
   out_type       rsp_qz_mm;
   byte_type      rsp_red;
   byte_type      rsp_green;
   byte_type      rsp_blue;
   logic          csr_we;
   csr_index_type csr_index;
   logic [63:0]   csr_wdata;

   int mismatch_count;
   int results_owed;
   int sender_idle_pct;
   int receiver_idle_pct;
   int stall_requests;
   int cycle_count;

   // Decimation factor of each random round; the extremes are always visited.
   int round_keep[ROUNDS] = '{2, 3, 1, 255, 4, 7, 1, 1, 0, 2};

   point_unpack_decimate_transform #(
      .COEF_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_px_mm       (req_px_mm),
      .req_py_mm       (req_py_mm),
      .req_pz_mm       (req_pz_mm),
      .req_color_rg    (req_color_rg),
      .req_color_b     (req_color_b),
      .req_end_of_frame(req_end_of_frame),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_qx_mm       (rsp_qx_mm),
      .rsp_qy_mm       (rsp_qy_mm),
      .rsp_qz_mm       (rsp_qz_mm),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   point_unpack_decimate_transform_checker #(
      .COEF_FRAC_BITS(FRAC_BITS)
   ) transform_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_px_mm       (req_px_mm),
      .req_py_mm       (req_py_mm),
      .req_pz_mm       (req_pz_mm),
      .req_color_rg    (req_color_rg),
      .req_color_b     (req_color_b),
      .req_end_of_frame(req_end_of_frame),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_qx_mm       (rsp_qx_mm),
      .rsp_qy_mm       (rsp_qy_mm),
      .rsp_qz_mm       (rsp_qz_mm),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_owed    (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("point_unpack_decimate_transform_test failed");
      $finish;
   end

   // Receiver: random back-pressure, plus a long hold-off whenever the
   // stimulus asks for one.
   initial begin
      int stalls_served;
      int hold_left;
      stalls_served = 0;
      hold_left     = 0;
      rsp_ready     = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            hold_left     = 90;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   function automatic row_type pack_row(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                                        logic [15:0] shift_mm);
      return {shift_mm, cz, cy, cx};
   endfunction

   // Coefficients lean towards the extremes, unity and zero.
   function automatic logic [15:0] pick_coef();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h4000;
         3: return 16'h0000;
         4: return 16'hC000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Offers one point and holds it until the transaction completes. Called
   // and returning at a falling edge.
   task automatic offer_point(coord_type x, coord_type y, coord_type z, logic [15:0] rg,
                              logic [15:0] b, logic eof);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_px_mm        = x;
      req_py_mm        = y;
      req_pz_mm        = z;
      req_color_rg     = rg;
      req_color_b      = b;
      req_end_of_frame = eof;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic offer_random_point();
      offer_point(pick_coord(), pick_coord(), pick_coord(), 16'($urandom), 16'($urandom),
                  $urandom_range(7) == 0);
   endtask

   // Stops offering, waits for every owed result, then idles before
   // returning.
   task automatic settle();
      req_valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Main stimulus.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_px_mm         = '0;
      req_py_mm         = '0;
      req_pz_mm         = '0;
      req_color_rg      = '0;
      req_color_b       = '0;
      req_end_of_frame  = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_ROW_X;
      csr_wdata         = '0;
      sender_idle_pct   = 38;
      receiver_idle_pct = 71;
      stall_requests    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Identity transform after reset: coordinate and colour extremes.
      offer_point(16'sd0, 16'sd0, 16'sd0, 16'h0000, 16'h0000, 1'b0);
      offer_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
      offer_point(16'sh8000, 16'sh8000, 16'sh8000, 16'h00FF, 16'hFF00, 1'b1);
      offer_point(16'sh7FFF, 16'sh8000, 16'sd1, 16'hFF00, 16'h00FF, 1'b0);
      offer_point(-16'sd1, 16'sd1, -16'sd1, 16'h1234, 16'hAB56, 1'b1);
      settle();

      // Largest gains and offsets of both signs, and a half-scale row that
      // lands exactly on the rounding midpoint for odd inputs.
      write_reg(CSR_ROW_X, pack_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      write_reg(CSR_ROW_Y, pack_row(16'h8000, 16'h8000, 16'h8000, 16'h8000));
      write_reg(CSR_ROW_Z, pack_row(16'h2000, 16'hE000, 16'h0001, 16'h0000));
      write_reg(CSR_KEEP_EVERY, 64'd1);
      offer_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hA55A, 16'h5AA5, 1'b0);
      offer_point(16'sh8000, 16'sh8000, 16'sh8000, 16'h5AA5, 16'hA55A, 1'b0);
      offer_point(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0F0F, 16'hF0F0, 1'b0);
      offer_point(16'sd1, 16'sd0, 16'sd0, 16'h0102, 16'h0304, 1'b0);
      offer_point(-16'sd1, 16'sd0, 16'sd0, 16'h0506, 16'h0708, 1'b0);
      offer_point(16'sd3, -16'sd3, 16'sd0, 16'h090A, 16'h0B0C, 1'b1);
      settle();

      // Decimation by three with an end of frame cutting a group short.
      write_reg(CSR_KEEP_EVERY, 64'd3);
      offer_point(16'sd10, 16'sd20, 16'sd30, 16'h1111, 16'h2222, 1'b0);
      offer_point(16'sd11, 16'sd21, 16'sd31, 16'h3333, 16'h4444, 1'b1);
      offer_point(16'sd12, 16'sd22, 16'sd32, 16'h5555, 16'h6666, 1'b0);
      offer_point(16'sd13, 16'sd23, 16'sd33, 16'h7777, 16'h8888, 1'b0);
      offer_point(16'sd14, 16'sd24, 16'sd34, 16'h9999, 16'hAAAA, 1'b0);
      settle();

      // Factor lowered mid-frame below the current phase.
      write_reg(CSR_KEEP_EVERY, 64'd5);
      repeat (3) offer_random_point();
      offer_point(16'sd1, 16'sd2, 16'sd3, 16'hBBBB, 16'hCCCC, 1'b0);
      settle();
      write_reg(CSR_KEEP_EVERY, 64'd2);
      repeat (3) offer_point(pick_coord(), pick_coord(), pick_coord(), 16'($urandom),
                             16'($urandom), 1'b0);
      settle();

      // A zero factor, written with the unused upper bits set, keeps every point.
      write_reg(CSR_KEEP_EVERY, 64'hFFFF_FFFF_FFFF_FF00);
      offer_random_point();
      offer_random_point();
      settle();

      // Random rounds, each with fresh rows and a factor; the idling pattern
      // changes from a slow receiver to a slow sender to none at all.
      for (int round = 0; round < ROUNDS; round++) begin
         if (round < 4) begin
            sender_idle_pct   = 38;
            receiver_idle_pct = 71;
         end else if (round < 7) begin
            sender_idle_pct   = 71;
            receiver_idle_pct = 38;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         write_reg(CSR_ROW_X, pack_row(pick_coef(), pick_coef(), pick_coef(), pick_coef()));
         write_reg(CSR_ROW_Y, pack_row(pick_coef(), pick_coef(), pick_coef(), pick_coef()));
         write_reg(CSR_ROW_Z, pack_row(pick_coef(), pick_coef(), pick_coef(), pick_coef()));
         write_reg(CSR_KEEP_EVERY, {$urandom, $urandom} & ~64'hFF | 64'(round_keep[round]));
         for (int n = 0; n < ROUND_ITEMS; n++) begin
            // With every point kept and no idling, a long receiver hold-off
            // fills the pipeline and blocks the input.
            if (round == 7 && n == 5) stall_requests++;
            offer_random_point();
         end
         settle();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("point_unpack_decimate_transform_test passed");
      end else begin
         $display("point_unpack_decimate_transform_test failed");
      end
      $finish;
   end

endmodule
